// ===== rtl/core/optr_pkg.sv =====
// Shared types and constants for the OBD-II PID table responder.
package optr_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int MAX_SOURCES = 64;

    localparam int PID_W   = 8;
    localparam int MODE_W  = 8;
    localparam int SRC_W   = 6;
    localparam int COUNT_W = 7;
    localparam int WIN_N   = 8;
    localparam int WIN_W   = 32;

    localparam logic [7:0] SERVICE_REPLY = 8'h41;
    localparam logic [7:0] MODE_CURRENT  = 8'h01;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEARED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_SKIPPED   = 3'd3,
        ST_FULL      = 3'd4,
        ST_BITMAP    = 3'd5,
        ST_FOUND     = 3'd6,
        ST_REFUSED   = 3'd7
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

endpackage

// ===== rtl/core/optr_ctrl.sv =====
// Controller state machine: accept a word, execute it, hold the result.
module optr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output optr_pkg::t_cmd o_cmd
);
    import optr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);

endmodule

// ===== rtl/core/optr_dp.sv =====
// Datapath: presence vector, source memory, entry count and result registers.
module optr_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  optr_pkg::t_cmd                 i_cmd,
    input  logic [1:0]                     i_func,
    input  logic [optr_pkg::PID_W-1:0]     i_pid,
    input  logic [optr_pkg::MODE_W-1:0]    i_mode,
    input  logic [optr_pkg::SRC_W-1:0]     i_source_index,
    input  logic                           i_source_enabled,
    output logic [2:0]                     o_status,
    output logic [7:0]                     o_reply_service,
    output logic [optr_pkg::PID_W-1:0]     o_reply_pid,
    output logic [optr_pkg::WIN_W-1:0]     o_bitmap,
    output logic [optr_pkg::SRC_W-1:0]     o_found_index,
    output logic [optr_pkg::COUNT_W-1:0]   o_entry_count
);
    import optr_pkg::*;

    // Presence bit of PID p sits at r_present[p[7:5]][p[4:0]].
    logic [WIN_N-1:0][WIN_W-1:0] r_present;
    logic [WIN_N-1:0]            r_grp;
    logic [WIN_N-1:0]            n_grp;
    logic [COUNT_W-1:0]          r_count;
    logic [SRC_W-1:0]            r_src_mem [256];
    logic [SRC_W-1:0]            r_rd_src;

    t_func               r_func;
    logic [PID_W-1:0]    r_pid;
    logic [MODE_W-1:0]   r_mode;
    logic [SRC_W-1:0]    r_src;
    logic                r_en;

    t_status             n_status;
    logic [7:0]          n_service;
    logic [PID_W-1:0]    n_rpid;
    logic [WIN_W-1:0]    n_bits;
    logic [SRC_W-1:0]    n_found;
    logic [COUNT_W-1:0]  n_count;
    logic                n_clear;
    logic                n_insert;

    logic [2:0]          win;
    logic [WIN_W-1:0]    slice;
    logic [WIN_N-1:0]    above;
    logic                pid_hit;

    // Any present PID in window h (base+1 .. base+32) of each window.
    always_comb begin
        for (int h = 0; h < WIN_N - 1; h++) begin
            n_grp[h] = (|r_present[h][WIN_W-1:1]) | r_present[h+1][0];
        end
        n_grp[WIN_N-1] = |r_present[WIN_N-1][WIN_W-1:1];
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    // Capture the word and start the source memory read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= t_func'(i_func);
            r_pid    <= i_pid;
            r_mode   <= i_mode;
            r_src    <= i_source_index;
            r_en     <= i_source_enabled;
            r_rd_src <= r_src_mem[i_pid];
        end
    end

    assign win     = r_pid[7:5];
    assign pid_hit = r_present[r_pid[7:5]][r_pid[4:0]];

    // Window slice, first PID of the window in the MSB.
    always_comb begin
        for (int off = 0; off < WIN_W - 1; off++) begin
            slice[WIN_W-1-off] = r_present[win][off+1];
        end
        slice[0] = (win != 3'(WIN_N - 1)) ? r_present[win + 3'd1][0] : 1'b0;
        for (int h = 0; h < WIN_N; h++) begin
            above[h] = (3'(h) > win) ? r_grp[h] : 1'b0;
        end
    end

    always_comb begin
        n_status  = ST_REFUSED;
        n_service = '0;
        n_rpid    = '0;
        n_bits    = '0;
        n_found   = '0;
        n_count   = r_count;
        n_clear   = 1'b0;
        n_insert  = 1'b0;
        case (r_func)
            FUNC_CLEAR: begin
                n_clear  = 1'b1;
                n_count  = '0;
                n_status = ST_CLEARED;
            end
            FUNC_INSERT: begin
                if (int'(r_count) >= MAX_ENTRIES) begin
                    n_status = ST_FULL;
                end else if (!r_en || r_pid == '0 || int'(r_src) >= MAX_SOURCES) begin
                    n_status = ST_SKIPPED;
                end else if (pid_hit) begin
                    n_status = ST_DUPLICATE;
                end else begin
                    n_insert = 1'b1;
                    n_count  = r_count + 7'd1;
                    n_status = ST_INSERTED;
                end
            end
            FUNC_QUERY: begin
                n_rpid = r_pid;
                if (r_mode != MODE_CURRENT) begin
                    n_status = ST_REFUSED;
                end else if (r_pid[4:0] == 5'd0) begin
                    // Continuation bit flags a present PID past this window.
                    n_bits    = slice | {{(WIN_W-1){1'b0}}, |above};
                    n_service = SERVICE_REPLY;
                    n_status  = ST_BITMAP;
                end else if (pid_hit) begin
                    n_found   = r_rd_src;
                    n_service = SERVICE_REPLY;
                    n_status  = ST_FOUND;
                end else begin
                    n_status = ST_REFUSED;
                end
            end
            default: begin
                n_status = ST_REFUSED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_count   <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
            if (n_clear) begin
                r_present <= '0;
            end else if (n_insert) begin
                r_present[r_pid[7:5]][r_pid[4:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && n_insert) begin
            r_src_mem[r_pid] <= r_src;
        end
    end

    // Result registers, held until the word is taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_status        <= n_status;
            o_reply_service <= n_service;
            o_reply_pid     <= n_rpid;
            o_bitmap        <= n_bits;
            o_found_index   <= n_found;
            o_entry_count   <= n_count;
        end
    end

endmodule

// ===== rtl/core/obd_pid_table_responder.sv =====
// Top level of the OBD-II Mode 01 PID table responder.
// Handles one word at a time: a word is captured in the idle state, executed
// in the execute state and its result is offered in the output state, held
// until taken; the next word is accepted once the result has gone. The
// source-index memory is read into a register when the word is captured, and
// execute uses that registered value. The presence vector is a register that
// a clear word and reset both clear as a whole, so the block needs no clearing
// pass.
module obd_pid_table_responder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_func,
    input  logic [optr_pkg::PID_W-1:0]     i_pid,
    input  logic [optr_pkg::MODE_W-1:0]    i_mode,
    input  logic [optr_pkg::SRC_W-1:0]     i_source_index,
    input  logic                           i_source_enabled,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_status,
    output logic [7:0]                     o_reply_service,
    output logic [optr_pkg::PID_W-1:0]     o_reply_pid,
    output logic [optr_pkg::WIN_W-1:0]     o_bitmap,
    output logic [optr_pkg::SRC_W-1:0]     o_found_index,
    output logic [optr_pkg::COUNT_W-1:0]   o_entry_count
);
    import optr_pkg::*;

    t_cmd cmd;

    optr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    optr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_func           (i_func),
        .i_pid            (i_pid),
        .i_mode           (i_mode),
        .i_source_index   (i_source_index),
        .i_source_enabled (i_source_enabled),
        .o_status         (o_status),
        .o_reply_service  (o_reply_service),
        .o_reply_pid      (o_reply_pid),
        .o_bitmap         (o_bitmap),
        .o_found_index    (o_found_index),
        .o_entry_count    (o_entry_count)
    );

endmodule
